### hdl/bprq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprq_pkg: shared types for the button press/release qualifier
// Event kinds, register indexes and the words passed between modules.
// ----------------------------------------------------------------------------
package bprq_pkg;

	typedef enum logic [1:0] {
		KIND_PRESS    = 2'd0,
		KIND_RELEASE  = 2'd1,
		KIND_DURATION = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CFG_ACTIVE_LOW    = 2'd0,
		CFG_EVENT_MODE    = 2'd1,
		CFG_RELEASE_COUNT = 2'd2
	} cfg_reg_t;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned CNT_W       = 8;
	localparam int unsigned TIME_W      = 32;

	localparam logic [CNT_W-1:0] RELEASE_COUNT_RST = 8'd5;

	typedef struct packed {
		logic             active_low;
		logic             event_mode;
		logic [CNT_W-1:0] release_count;
	} cfg_t;

	typedef struct packed {
		logic              pin_level;
		logic              check_point;
		logic [TIME_W-1:0] now_ticks;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic [TIME_W-1:0] time_val;
	} result_t;

endpackage

### hdl/button_press_release_qualifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_release_qualifier_top: debounced button press/release events
// Input register, decision core and result register with config registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one pin sample word per tick:
//   pin_level, check_point strobe and the current now_ticks time.
//   Output channel (out_valid/out_ready) carries event_kind and event_time:
//   press/release times in event mode, held duration in duration mode.
//   Config port: cfg_we writes cfg_data into register cfg_index
//   (0 active_low, 1 event_mode, 2 release_count); write only while idle.
// Timing:
//   A word accepted lands in the input register, is decided by the core
//   combinationally and, once retired, has its result loaded into the
//   result register that drives out_valid. One word per cycle sustained
//   unless out_ready stalls a result; the single decision stage sets the rate.
// Reset:
//   Clears both valid flags and the button state to idle; config returns to
//   active_low=1, event_mode=1, release_count=5.
// Stall:
//   While out_ready is low the result register holds; a word that yields
//   no result still moves through, one with a result waits in the input
//   register and in_ready drops only then.
// ----------------------------------------------------------------------------
module button_press_release_qualifier_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 pin_level,
	input  logic                                 check_point,
	input  logic [31:0]                          now_ticks,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           event_kind,
	output logic [31:0]                          event_time,
	input  logic                                 cfg_we,
	input  logic [bprq_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bprq_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bprq_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_q;

	logic    res_valid;
	result_t res;
	logic    go;
	logic    advance;

	// Config registers: take effect at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low    <= 1'b1;
			cfg_q.event_mode    <= 1'b1;
			cfg_q.release_count <= RELEASE_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE_LOW:    cfg_q.active_low    <= cfg_data[0];
				CFG_EVENT_MODE:    cfg_q.event_mode    <= cfg_data[0];
				CFG_RELEASE_COUNT: cfg_q.release_count <= cfg_data[CNT_W-1:0];
				default: ; // unmapped index: drop
			endcase
		end
	end

	// Stage 1 may retire when it makes no result or the result slot frees.
	assign go       = !res_valid || !out_valid_q || out_ready;
	assign advance  = valid_s1 && go;
	assign in_ready = !valid_s1 || go;

	// Input register: hold the word until the core retires it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.pin_level   <= pin_level;
			item_s1.check_point <= check_point;
			item_s1.now_ticks   <= now_ticks;
		end
	end

	bprq_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (valid_s1),
		.item       (item_s1),
		.advance    (advance),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Result register: load on a new result, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = out_q.kind;
	assign event_time = out_q.time_val;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(advance && res_valid))
		else $error("result register overwritten while stalled");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a waiting word");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input blocked with empty stage");

endmodule

### hdl/bprq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprq_core: press/release decision and button state
// Holds the held flag, press time and inactive count; decides one result.
// ----------------------------------------------------------------------------
module bprq_core (
	input  logic              clk,
	input  logic              arst_n,
	input  bprq_pkg::cfg_t    cfg,
	input  logic              item_valid,
	input  bprq_pkg::item_t   item,
	input  logic              advance,
	output logic              res_valid,
	output bprq_pkg::result_t res
);
	import bprq_pkg::*;

	logic              held_q;
	logic [TIME_W-1:0] press_time_q;
	logic [CNT_W-1:0]  inactive_count_q;

	logic              active;
	logic [CNT_W-1:0]  limit;
	logic [CNT_W-1:0]  cnt_inc;
	logic              held_d;
	logic [TIME_W-1:0] press_time_d;
	logic [CNT_W-1:0]  inactive_count_d;

	assign active  = cfg.active_low ? ~item.pin_level : item.pin_level;
	assign limit   = (cfg.release_count == '0) ? CNT_W'(1) : cfg.release_count;
	assign cnt_inc = inactive_count_q + CNT_W'(1);

	always_comb begin
		held_d           = held_q;
		press_time_d     = press_time_q;
		inactive_count_d = inactive_count_q;
		res_valid        = 1'b0;
		res.kind         = KIND_PRESS;
		res.time_val     = item.now_ticks;
		if (!held_q) begin
			if (active) begin
				held_d           = 1'b1;
				press_time_d     = item.now_ticks;
				inactive_count_d = '0;
				res_valid        = item_valid & cfg.event_mode;
			end
		end else if (item.check_point) begin
			if (active) begin
				inactive_count_d = '0;
			end else if (cnt_inc < limit) begin
				inactive_count_d = cnt_inc;
			end else begin
				// release: report event or held duration
				held_d           = 1'b0;
				inactive_count_d = '0;
				res_valid        = item_valid;
				if (cfg.event_mode) begin
					res.kind = KIND_RELEASE;
				end else begin
					res.kind     = KIND_DURATION;
					res.time_val = item.now_ticks - press_time_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q           <= 1'b0;
			press_time_q     <= '0;
			inactive_count_q <= '0;
		end else if (advance) begin
			held_q           <= held_d;
			press_time_q     <= press_time_d;
			inactive_count_q <= inactive_count_d;
		end
	end

	a_press_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_PRESS |-> !held_q)
		else $error("press result while already held");

	a_count_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!held_q |-> inactive_count_q == '0)
		else $error("inactive count nonzero while idle");

	a_release_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid && res.kind != KIND_PRESS |=> !held_q)
		else $error("release did not return to idle");

	a_advance_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> item_valid)
		else $error("state advanced without an item");

endmodule
